/* rtl/nearest_bone_assign_macros.svh */
// Assertion macros shared by the nearest-bone assignment RTL.
`ifndef NEAREST_BONE_ASSIGN_MACROS_SVH
`define NEAREST_BONE_ASSIGN_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define NBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest_bone_assign: same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define NBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest_bone_assign: next-cycle check failed");

`endif

/* rtl/nba_pkg.sv */
// Shared constants, codes and control types of the nearest-bone assignment block.
package nba_pkg;

  localparam int MAX_BONES = 16;
  localparam int ADDR_W    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int CNT_W     = $clog2(MAX_BONES + 1);

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ID_W    = 8;
  localparam int VTX_W   = 20;
  localparam int DIST_W  = 34;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 8;
  localparam int CFGI_W  = 1;

  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_type_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_BONE_COUNT = 1'b0,
    CFG_ROOT_ID    = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              load_bone;
    logic              start;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
  } nba_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] scan_len;
    logic             out_free;
  } nba_stat_t;

endpackage

/* rtl/nba_ctrl.sv */
// Controller state machine: sequences slot reads, pipeline drain and result hand-off.
`include "nearest_bone_assign_macros.svh"

module nba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_type,
  output logic               req_stall,
  input  nba_pkg::nba_stat_t stat,
  output nba_pkg::nba_cmd_t  cmd
);
  import nba_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             dcnt;
  logic             dcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      dcnt  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      dcnt  <= dcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dcnt_next  = dcnt;
    cmd        = '0;
    cmd.rd_addr = cnt[ADDR_W-1:0];
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req_type == REQ_CLASSIFY) begin
            cmd.start = 1'b1;
            cnt_next  = '0;
            if (stat.scan_len == '0) begin
              state_next = ST_RESULT;
            end else begin
              state_next = ST_SCAN;
            end
          end else begin
            cmd.load_bone = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == stat.scan_len - CNT_W'(1)) begin
          dcnt_next  = 1'b0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        dcnt_next = 1'b1;
        if (dcnt) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `NBA_ASSERT_NOW(a_scan_in_range, state == ST_SCAN, cnt < stat.scan_len)
  `NBA_ASSERT_NEXT(a_empty_goes_to_result,
    (state == ST_IDLE) && req_valid && (req_type == REQ_CLASSIFY) && (stat.scan_len == '0),
    state == ST_RESULT)
  `NBA_ASSERT_NEXT(a_drain_two_cycles, (state == ST_DRAIN) && dcnt, state == ST_RESULT)
  `NBA_ASSERT_NEXT(a_result_leaves_when_free,
    (state == ST_RESULT) && stat.out_free, state == ST_IDLE)

endmodule

/* rtl/nba_datapath.sv */
// Datapath: configuration, bone table, distance pipeline, running minimum and result register.
module nba_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [nba_pkg::CFGI_W-1:0]        cfg_index,
  input  logic [nba_pkg::CFG_W-1:0]         cfg_data,
  input  logic [nba_pkg::SLOT_W-1:0]        bone_slot,
  input  logic [nba_pkg::ID_W-1:0]          bone_ident,
  input  logic signed [nba_pkg::COORD_W-1:0] pos_x,
  input  logic signed [nba_pkg::COORD_W-1:0] pos_y,
  input  logic signed [nba_pkg::COORD_W-1:0] pos_z,
  input  logic [nba_pkg::VTX_W-1:0]         vertex_index,
  input  nba_pkg::nba_cmd_t                 cmd,
  output nba_pkg::nba_stat_t                stat,
  input  logic                              res_stall,
  output logic                              res_valid,
  output logic [nba_pkg::VTX_W-1:0]         vertex_out,
  output logic [nba_pkg::ID_W-1:0]          nearest_id,
  output logic [nba_pkg::DIST_W-1:0]        min_dist_sq
);
  import nba_pkg::*;

  logic [COUNT_W-1:0] bone_count;
  logic [ID_W-1:0]    root_id;

  logic [3*COORD_W-1:0] bone_position [MAX_BONES];
  logic [ID_W-1:0]      bone_tag [MAX_BONES];

  logic signed [COORD_W-1:0] vtx_x;
  logic signed [COORD_W-1:0] vtx_y;
  logic signed [COORD_W-1:0] vtx_z;
  logic [VTX_W-1:0]          vtx_idx;

  logic [3*COORD_W-1:0] rd_pos;
  logic [ID_W-1:0]      rd_tag;
  logic                 rd_v;

  logic signed [COORD_W-1:0]  bx;
  logic signed [COORD_W-1:0]  by;
  logic signed [COORD_W-1:0]  bz;
  logic signed [DIFF_W-1:0]   dx;
  logic signed [DIFF_W-1:0]   dy;
  logic signed [DIFF_W-1:0]   dz;
  logic signed [2*DIFF_W-1:0] px;
  logic signed [2*DIFF_W-1:0] py;
  logic signed [2*DIFF_W-1:0] pz;

  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;
  logic [SQ_W-1:0] sq_z;
  logic [ID_W-1:0] sq_tag;
  logic            sq_v;

  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_d;
  logic [ID_W-1:0]   best_id;
  logic              slot_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count <= '0;
      root_id    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BONE_COUNT: bone_count <= cfg_data[COUNT_W-1:0];
        CFG_ROOT_ID:    root_id    <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts above the table size saturate at the table size.
  always_comb begin
    if (32'(bone_count) > MAX_BONES) begin
      stat.scan_len = CNT_W'(MAX_BONES);
    end else begin
      stat.scan_len = CNT_W'(bone_count);
    end
    stat.out_free = !res_valid || !res_stall;
  end

  assign slot_ok = 32'(bone_slot) < MAX_BONES;

  always_ff @(posedge clk) begin
    if (cmd.load_bone && slot_ok) begin
      bone_position[ADDR_W'(bone_slot)] <= {pos_x, pos_y, pos_z};
      bone_tag[ADDR_W'(bone_slot)]      <= bone_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_pos <= bone_position[cmd.rd_addr];
      rd_tag <= bone_tag[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vtx_x   <= pos_x;
      vtx_y   <= pos_y;
      vtx_z   <= pos_z;
      vtx_idx <= vertex_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      sq_v <= 1'b0;
    end else begin
      rd_v <= cmd.rd_en;
      sq_v <= rd_v;
    end
  end

  assign bx = rd_pos[3*COORD_W-1:2*COORD_W];
  assign by = rd_pos[2*COORD_W-1:COORD_W];
  assign bz = rd_pos[COORD_W-1:0];
  assign dx = DIFF_W'(vtx_x) - DIFF_W'(bx);
  assign dy = DIFF_W'(vtx_y) - DIFF_W'(by);
  assign dz = DIFF_W'(vtx_z) - DIFF_W'(bz);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // A square of a 17-bit difference is never negative and fits 32 bits.
  always_ff @(posedge clk) begin
    sq_x   <= px[SQ_W-1:0];
    sq_y   <= py[SQ_W-1:0];
    sq_z   <= pz[SQ_W-1:0];
    sq_tag <= rd_tag;
  end

  assign dist_sum = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);

  // The "no bone" mark is above every real distance, so the first slot always wins.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_d  <= DIST_NONE;
      best_id <= root_id;
    end else if (sq_v && (dist_sum < best_d)) begin
      best_d  <= dist_sum;
      best_id <= sq_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      vertex_out  <= vtx_idx;
      nearest_id  <= best_id;
      min_dist_sq <= best_d;
    end
  end

endmodule

/* rtl/nearest_bone_assign.sv */
// Top level of the nearest-bone assignment block: controller and datapath.
// Usage:
// The request channel (req_valid, req_stall) moves one word per accepted edge. A word with
// req_type low loads bone_slot with a position and bone_ident and gives no result; a word
// with req_type high classifies the vertex at pos_x/pos_y/pos_z and gives one result word.
// The result channel (res_valid, res_stall) returns vertex_out, nearest_id and min_dist_sq.
// A load word leaves the block idle and ready for the next word. A classify word searches
// N slots, N being bone_count saturated at the table size: one slot is read per cycle from
// the single read port of the bone table, then the square-and-sum pipeline drains and the
// result register is written; no new word is accepted until then. With N of zero the word
// skips the search and drain and returns root_id with an all-ones distance.
// The configuration port (cfg_write, cfg_index, cfg_data) is to be written only while idle
// by the user; the block itself does not enforce it.
// Reset clears the configuration registers, the state machine and the result valid flag;
// the bone table keeps no reset and must be loaded before it is searched.
// While the receiver stalls, a waiting result holds and the block can still accept load
// words and one classify word; it completes that search and then waits until the result
// is taken.
module nearest_bone_assign (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [nba_pkg::CFGI_W-1:0]         cfg_index,
  input  logic [nba_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               req_type,
  input  logic [nba_pkg::SLOT_W-1:0]         bone_slot,
  input  logic [nba_pkg::ID_W-1:0]           bone_ident,
  input  logic signed [nba_pkg::COORD_W-1:0] pos_x,
  input  logic signed [nba_pkg::COORD_W-1:0] pos_y,
  input  logic signed [nba_pkg::COORD_W-1:0] pos_z,
  input  logic [nba_pkg::VTX_W-1:0]          vertex_index,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [nba_pkg::VTX_W-1:0]          vertex_out,
  output logic [nba_pkg::ID_W-1:0]           nearest_id,
  output logic [nba_pkg::DIST_W-1:0]         min_dist_sq
);
  import nba_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  nba_cmd_t  cmd;
  nba_stat_t stat;

  nba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  nba_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bone_slot    (bone_slot),
    .bone_ident   (bone_ident),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .vertex_index (vertex_index),
    .cmd          (cmd),
    .stat         (stat),
    .res_stall    (res_stall),
    .res_valid    (res_valid),
    .vertex_out   (vertex_out),
    .nearest_id   (nearest_id),
    .min_dist_sq  (min_dist_sq)
  );

endmodule

/* sim/nearest_bone_assign_tb.sv */
// Self-checking testbench for the nearest-bone assignment block.
`timescale 1ns / 1ps

module nearest_bone_assign_tb;
  import nba_pkg::*;

  // Longest search is sixteen slots plus the pipeline drain; DRAIN_CYCLES is the quiet
  // time that wait_idle adds after the last result for the block to settle.
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 4000;
  localparam int ROUNDS       = 12;
  localparam int ROUND_WORDS  = 132;

  // One request word as it travels over the request channel.
  typedef struct {
    req_type_t                  kind;
    logic [SLOT_W-1:0]          slot;
    logic [ID_W-1:0]            ident;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [VTX_W-1:0]           vidx;
  } bone_word_t;

  // One result word: the classified vertex and its winning bone.
  typedef struct {
    logic [VTX_W-1:0]  vertex;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dist_sq;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_write = 1'b0;
  logic [CFGI_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data  = '0;

  logic                      req_valid    = 1'b0;
  logic                      req_stall;
  logic                      req_type     = 1'b0;
  logic [SLOT_W-1:0]         bone_slot    = '0;
  logic [ID_W-1:0]           bone_ident   = '0;
  logic signed [COORD_W-1:0] pos_x        = '0;
  logic signed [COORD_W-1:0] pos_y        = '0;
  logic signed [COORD_W-1:0] pos_z        = '0;
  logic [VTX_W-1:0]          vertex_index = '0;

  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [VTX_W-1:0]          vertex_out;
  logic [ID_W-1:0]           nearest_id;
  logic [DIST_W-1:0]         min_dist_sq;

  nearest_bone_assign u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .bone_slot    (bone_slot),
    .bone_ident   (bone_ident),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .vertex_index (vertex_index),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .vertex_out   (vertex_out),
    .nearest_id   (nearest_id),
    .min_dist_sq  (min_dist_sq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be driven, and the results the block still owes us.
  bone_word_t pending_words[$];
  hit_t       expected_hits[$];

  // The predictor's own copy of the bone table and of the two registers.
  logic signed [COORD_W-1:0] tbl_x [MAX_BONES];
  logic signed [COORD_W-1:0] tbl_y [MAX_BONES];
  logic signed [COORD_W-1:0] tbl_z [MAX_BONES];
  logic [ID_W-1:0]           tbl_id [MAX_BONES];
  logic [COUNT_W-1:0]        live_count = '0;
  logic [ID_W-1:0]           live_root  = '0;

  // The generator keeps the bone positions it has queued, so that it can aim
  // vertices at or near a bone and build exact ties.
  logic signed [COORD_W-1:0] gen_x [MAX_BONES];
  logic signed [COORD_W-1:0] gen_y [MAX_BONES];
  logic signed [COORD_W-1:0] gen_z [MAX_BONES];

  int  words_queued   = 0;
  int  words_accepted = 0;
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  req_taken      = 1'b0;
  bit  calm           = 1'b0;
  int  send_gap       = 0;
  int  stall_left     = 0;
  bone_word_t next_word;
  bone_word_t seen_word;
  hit_t       want_hit;

  // Prints one line per mismatch, up to a sensible number, and counts them all.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100)
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Works out the result of a classify word against the predictor's table.
  // The search runs in slot order and replaces the best only on a strictly
  // smaller distance, so ties go to the earlier slot. With no slot searched
  // the answer is root_id with the all-ones distance.
  function automatic hit_t nearest_bone(input bone_word_t w);
    hit_t   h;
    int     span;
    longint dx, dy, dz, d;
    bit     found;
    h.vertex  = w.vidx;
    h.id      = live_root;
    h.dist_sq = DIST_NONE;
    found     = 1'b0;
    span      = (int'(live_count) > MAX_BONES) ? MAX_BONES : int'(live_count);
    for (int i = 0; i < span; i++) begin
      dx = longint'(w.x) - longint'(tbl_x[i]);
      dy = longint'(w.y) - longint'(tbl_y[i]);
      dz = longint'(w.z) - longint'(tbl_z[i]);
      d  = dx * dx + dy * dy + dz * dz;
      if (!found || d < longint'(h.dist_sq)) begin
        found     = 1'b1;
        h.dist_sq = d[DIST_W-1:0];
        h.id      = tbl_id[i];
      end
    end
    return h;
  endfunction

  // Applies one accepted word: a load updates the table, a classify expects a result.
  task automatic apply_word(input bone_word_t w);
    if (w.kind == REQ_LOAD) begin
      if (int'(w.slot) < MAX_BONES) begin
        tbl_x[w.slot]  = w.x;
        tbl_y[w.slot]  = w.y;
        tbl_z[w.slot]  = w.z;
        tbl_id[w.slot] = w.ident;
      end
    end else begin
      expected_hits.insert(expected_hits.size(), nearest_bone(w));
    end
  endtask

  // Sampling at the rising edge: register writes, the result monitor, request
  // acceptance and the count of cycles in which nothing moved.
  always @(posedge clk) begin
    if (rst) begin
      req_taken    = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BONE_COUNT: live_count = cfg_data[COUNT_W-1:0];
          CFG_ROOT_ID:    live_root  = cfg_data[ID_W-1:0];
          default: ;
        endcase
      end
      // The monitor runs before acceptance: a result at this edge can only
      // belong to a word taken at an earlier edge.
      if (res_valid && !res_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("result word with none expected", 64'(vertex_out), 64'd0);
        end else begin
          want_hit = expected_hits.pop_front();
          if (vertex_out !== want_hit.vertex)
            report_mismatch("vertex_out", 64'(vertex_out), 64'(want_hit.vertex));
          if (nearest_id !== want_hit.id)
            report_mismatch("nearest_id", 64'(nearest_id), 64'(want_hit.id));
          if (min_dist_sq !== want_hit.dist_sq)
            report_mismatch("min_dist_sq", 64'(min_dist_sq), 64'(want_hit.dist_sq));
        end
      end
      req_taken = req_valid && !req_stall;
      if (req_taken) begin
        seen_word.kind  = req_type_t'(req_type);
        seen_word.slot  = bone_slot;
        seen_word.ident = bone_ident;
        seen_word.x     = pos_x;
        seen_word.y     = pos_y;
        seen_word.z     = pos_z;
        seen_word.vidx  = vertex_index;
        apply_word(seen_word);
        words_accepted++;
      end
      if (req_taken || (res_valid && !res_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Request driver. A word stays on the bus until taken; between words the
  // sender sometimes goes quiet, with send_gap counting down the rest of the gap.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        req_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        req_valid    <= 1'b1;
        req_type     <= next_word.kind;
        bone_slot    <= next_word.slot;
        bone_ident   <= next_word.ident;
        pos_x        <= next_word.x;
        pos_y        <= next_word.y;
        pos_z        <= next_word.z;
        vertex_index <= next_word.vidx;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls at random in bursts, with stall_left counting down a burst.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Coordinates lean on the extremes now and then; otherwise any value.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  task automatic queue_load(input int slot, input logic [ID_W-1:0] ident,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
    bone_word_t w;
    w.kind  = REQ_LOAD;
    w.slot  = SLOT_W'(slot);
    w.ident = ident;
    w.x     = x;
    w.y     = y;
    w.z     = z;
    w.vidx  = VTX_W'($urandom());   // ignored by a load, toggled anyway
    gen_x[w.slot] = x;
    gen_y[w.slot] = y;
    gen_z[w.slot] = z;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  task automatic queue_classify(input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [COORD_W-1:0] z,
                                input logic [VTX_W-1:0] vidx);
    bone_word_t w;
    w.kind  = REQ_CLASSIFY;
    w.slot  = SLOT_W'($urandom());   // slot and ident mean nothing to a classify
    w.ident = ID_W'($urandom());
    w.x     = x;
    w.y     = y;
    w.z     = z;
    w.vidx  = vidx;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // Registers may only change while the block is idle: every queued word has
  // been taken, every result has come back, and the pipeline has drained.
  task automatic wait_idle();
    while (words_accepted != words_queued || expected_hits.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Watchdog: the run is abandoned once nothing has moved for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("nearest_bone_assign: mismatch");
    $finish;
  end

  initial begin
    int s, pick, cnt;
    logic signed [COORD_W-1:0] dx, dy, dz;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // With no slot searched, every classify answers root_id and the all-ones
    // distance. This runs before any load, so the empty table is never read.
    queue_classify(16'sh7fff, 16'sh7fff, 16'sh7fff, 20'hfffff);
    queue_classify(16'sh8000, 16'sh8000, 16'sh8000, 20'h00000);
    wait_idle();
    write_reg(CFG_ROOT_ID, 8'hff);
    queue_classify(16'sh0000, 16'sh0000, 16'sh0000, 20'h5a5a5);

    // Fill the whole table. Slots 0 and 1 sit at opposite corners of the
    // coordinate range; slot 4 shares slot 3's position to force a tie.
    queue_load(0, 8'h00, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_load(1, 8'hff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    for (s = 2; s < MAX_BONES; s++) begin
      if (s == 4)
        queue_load(s, 8'ha4, gen_x[3], gen_y[3], gen_z[3]);
      else
        queue_load(s, ID_W'($urandom()), rand_coord(), rand_coord(), rand_coord());
    end

    // One slot searched: the far corner gives the largest possible distance.
    wait_idle();
    write_reg(CFG_BONE_COUNT, 8'd1);
    queue_classify(16'sh7fff, 16'sh7fff, 16'sh7fff, VTX_W'($urandom()));
    queue_classify(16'sh8000, 16'sh8000, 16'sh8000, VTX_W'($urandom()));

    // A count beyond the table saturates; a vertex on slots 3 and 4 picks slot 3.
    wait_idle();
    write_reg(CFG_BONE_COUNT, 8'd31);
    queue_classify(gen_x[3], gen_y[3], gen_z[3], VTX_W'($urandom()));
    queue_classify(rand_coord(), rand_coord(), rand_coord(), VTX_W'($urandom()));

    // Random rounds, each under its own register setting. Every round starts
    // with the sender held back until all earlier results are home. The last
    // round, and some others, run with no idling at all.
    for (int round = 0; round < ROUNDS; round++) begin
      wait_idle();
      calm = (round == ROUNDS - 1) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = MAX_BONES;
        3:       cnt = 31;
        default: cnt = $urandom_range(0, 31);
      endcase
      write_reg(CFG_BONE_COUNT, CFG_W'(cnt));
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_ROOT_ID, CFG_W'($urandom_range(0, 255)));

      for (int k = 0; k < ROUND_WORDS; k++) begin
        s = $urandom_range(0, MAX_BONES - 1);
        if ($urandom_range(0, 3) == 0) begin
          // Loads sometimes copy another slot's position to set up ties.
          pick = $urandom_range(0, MAX_BONES - 1);
          if ($urandom_range(0, 3) == 0)
            queue_load(s, ID_W'($urandom()), gen_x[pick], gen_y[pick], gen_z[pick]);
          else
            queue_load(s, ID_W'($urandom()), rand_coord(), rand_coord(), rand_coord());
        end else begin
          case ($urandom_range(0, 2))
            0: queue_classify(gen_x[s], gen_y[s], gen_z[s], VTX_W'($urandom()));
            1: begin
              // A small step away from a bone keeps the race close.
              dx = COORD_W'(int'($urandom_range(0, 8)) - 4);
              dy = COORD_W'(int'($urandom_range(0, 8)) - 4);
              dz = COORD_W'(int'($urandom_range(0, 8)) - 4);
              queue_classify(gen_x[s] + dx, gen_y[s] + dy, gen_z[s] + dz,
                             VTX_W'($urandom()));
            end
            default: queue_classify(rand_coord(), rand_coord(), rand_coord(),
                                    VTX_W'($urandom()));
          endcase
        end
      end
    end

    wait_idle();
    if (expected_hits.size() != 0)
      report_mismatch("results never returned", 64'(expected_hits.size()), 64'd0);
    if (mismatch_count == 0)
      $display("nearest_bone_assign: match");
    else
      $display("nearest_bone_assign: mismatch");
    $finish;
  end

endmodule
